// ===== design/rv32adt_pkg.sv =====
`timescale 1ns / 1ps
package rv32adt_pkg;

   localparam logic [6:0]  OPC_AMO    = 7'b0101111;
   localparam logic [6:0]  OPC_OP     = 7'b0110011;
   localparam logic [6:0]  OPC_SYSTEM = 7'b1110011;
   localparam logic [11:0] CSR_TIME   = 12'hC01;
   localparam logic [11:0] CSR_TIMEH  = 12'hC81;
   localparam logic [4:0]  F5_LR      = 5'b00010;
   localparam logic [4:0]  F5_SC      = 5'b00011;
   localparam logic [6:0]  F7_MULDIV  = 7'b0000001;
   localparam logic [2:0]  F3_WORD    = 3'b010;

   localparam logic [4:0]  F5_SWAP = 5'h01;
   localparam logic [4:0]  F5_ADD  = 5'h00;
   localparam logic [4:0]  F5_XOR  = 5'h04;
   localparam logic [4:0]  F5_AND  = 5'h0C;
   localparam logic [4:0]  F5_OR   = 5'h08;
   localparam logic [4:0]  F5_MIN  = 5'h10;
   localparam logic [4:0]  F5_MAX  = 5'h14;
   localparam logic [4:0]  F5_MINU = 5'h18;
   localparam logic [4:0]  F5_MAXU = 5'h1C;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIX,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_div;
      logic div_last;
   } status_type;

endpackage

// ===== design/rv32adt_datapath.sv =====
`timescale 1ns / 1ps
module rv32adt_datapath
   import rv32adt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        fetch_ok,
   input  logic [31:0] instr_word,
   input  logic [31:0] src1_value,
   input  logic [31:0] src2_value,
   input  logic [31:0] mem_word,
   input  logic [31:0] time_value,
   output logic [103:0] result
);
   logic [6:0]  opc;
   logic [4:0]  rd, f5;
   logic [2:0]  f3;
   logic        ok, wr_rd, wr_mem, div_hit;
   logic [31:0] rdv, mdata, amo_res;
   logic        amo_ok;

   logic        res_v_ff, res_v_in;
   logic [31:0] res_a_ff, res_a_in;
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_q_ff, neg_q_in, neg_r_ff, neg_r_in, want_rem_ff, want_rem_in;
   logic        zero_ff, zero_in;
   logic [31:0] a_ff, a_in;
   logic [4:0]  rd_ff, rd_in;
   logic [103:0] result_ff, result_in;

   logic [32:0] trial;
   logic [31:0] rem_sh, mag_a, mag_b, div_val;
   logic        sgn;

   assign opc = instr_word[6:0];
   assign rd  = instr_word[11:7];
   assign f3  = instr_word[14:12];
   assign f5  = instr_word[31:27];
   assign div_hit = fetch_ok && opc == OPC_OP && instr_word[31:25] == F7_MULDIV && f3[2];
   assign status.is_div   = div_hit;
   assign status.div_last = cnt_ff == 6'd31;

   always_comb begin
      amo_ok  = 1'b1;
      amo_res = '0;
      case (f5)
         F5_SWAP: amo_res = src2_value;
         F5_ADD:  amo_res = mem_word + src2_value;
         F5_XOR:  amo_res = mem_word ^ src2_value;
         F5_AND:  amo_res = mem_word & src2_value;
         F5_OR:   amo_res = mem_word | src2_value;
         F5_MIN:  amo_res = ($signed(mem_word) < $signed(src2_value)) ? mem_word : src2_value;
         F5_MAX:  amo_res = ($signed(mem_word) > $signed(src2_value)) ? mem_word : src2_value;
         F5_MINU: amo_res = (mem_word < src2_value) ? mem_word : src2_value;
         F5_MAXU: amo_res = (mem_word > src2_value) ? mem_word : src2_value;
         default: amo_ok = 1'b0;
      endcase
   end

   assign sgn   = ~f3[0];
   assign mag_a = (sgn && src1_value[31]) ? 32'd0 - src1_value : src1_value;
   assign mag_b = (sgn && src2_value[31]) ? 32'd0 - src2_value : src2_value;
   assign rem_sh = {rem_ff[30:0], quo_ff[31]};
   assign trial  = {rem_ff, quo_ff[31]} - {1'b0, dsr_ff};

   always_comb begin
      div_val = want_rem_ff ? (neg_r_ff ? 32'd0 - rem_ff : rem_ff)
                            : (neg_q_ff ? 32'd0 - quo_ff : quo_ff);
      if (zero_ff) div_val = want_rem_ff ? a_ff : 32'hFFFF_FFFF;
   end

   always_comb begin
      ok = 1'b0; wr_rd = 1'b0; wr_mem = 1'b0; rdv = '0; mdata = '0;
      res_v_in = res_v_ff;
      res_a_in = res_a_ff;
      if (fetch_ok && opc == OPC_SYSTEM && f3 == F3_WORD) begin
         if (instr_word[31:20] == CSR_TIME) begin
            ok = 1'b1; wr_rd = 1'b1; rdv = time_value;
         end else if (instr_word[31:20] == CSR_TIMEH) begin
            ok = 1'b1; wr_rd = 1'b1;
         end
      end else if (fetch_ok && opc == OPC_AMO && f3 == F3_WORD) begin
         if (f5 == F5_LR) begin
            ok = 1'b1; wr_rd = 1'b1; rdv = mem_word;
            res_v_in = 1'b1; res_a_in = src1_value;
         end else if (f5 == F5_SC) begin
            ok = 1'b1; wr_rd = 1'b1; res_v_in = 1'b0;
            if (res_v_ff && res_a_ff == src1_value) begin
               wr_mem = 1'b1; mdata = src2_value;
            end else begin
               rdv = 32'd1;
            end
         end else if (amo_ok) begin
            ok = 1'b1; wr_rd = 1'b1; rdv = mem_word; wr_mem = 1'b1; mdata = amo_res;
         end
      end
      if (rd == 5'd0) wr_rd = 1'b0;
      if (!cmd.load) begin
         res_v_in = res_v_ff;
         res_a_in = res_a_ff;
      end
   end

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; dsr_in = dsr_ff; cnt_in = cnt_ff;
      neg_q_in = neg_q_ff; neg_r_in = neg_r_ff; want_rem_in = want_rem_ff;
      zero_in = zero_ff; a_in = a_ff; rd_in = rd_ff; result_in = result_ff;
      if (cmd.load) begin
         rem_in = '0; quo_in = mag_a; dsr_in = mag_b; cnt_in = '0;
         neg_q_in = sgn && (src1_value[31] ^ src2_value[31]);
         neg_r_in = sgn && src1_value[31];
         want_rem_in = f3[1];
         zero_in = src2_value == 32'd0;
         a_in = src1_value; rd_in = rd;
         result_in = {ok, wr_rd, wr_rd ? rd : 5'd0, wr_rd ? rdv : 32'd0,
                      wr_mem, wr_mem ? src1_value : 32'd0, wr_mem ? mdata : 32'd0};
      end
      if (cmd.step) begin
         cnt_in = cnt_ff + 6'd1;
         if (!trial[32]) begin
            rem_in = trial[31:0]; quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh; quo_in = {quo_ff[30:0], 1'b0};
         end
      end
      if (cmd.finish) begin
         result_in = {1'b1, rd_ff != 5'd0, rd_ff, rd_ff != 5'd0 ? div_val : 32'd0,
                      1'b0, 32'd0, 32'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_v_ff <= 1'b0;
      end else begin
         res_v_ff <= res_v_in;
      end
      res_a_ff <= res_a_in; rem_ff <= rem_in; quo_ff <= quo_in; dsr_ff <= dsr_in;
      cnt_ff <= cnt_in; neg_q_ff <= neg_q_in; neg_r_ff <= neg_r_in;
      want_rem_ff <= want_rem_in; zero_ff <= zero_in; a_ff <= a_in; rd_ff <= rd_in;
      result_ff <= result_in;
   end

   assign result = result_ff;
endmodule

// ===== design/rv32adt_control.sv =====
`timescale 1ns / 1ps
module rv32adt_control
   import rv32adt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      in_ready = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = status.is_div ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (status.div_last) state_in = ST_FIX;
         end
         // fix up signs and latch the word before DONE shows it
         ST_FIX: begin
            cmd.finish = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            out_valid = 1'b1;
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== design/rv32_atomic_divide_trap_unit.sv =====
`timescale 1ns / 1ps
// channel | direction | tdata fields (low bit up)
// req     | in        | fetch_ok, instr_word, src1_value, src2_value, mem_word, time_value
// rsp     | out       | handled, rd_write, rd_index, rd_data, mem_write, mem_addr, mem_data
// Non-divide words raise rsp_tvalid in the cycle after accept; divides pass through
// the 32 steps of the radix-2 restoring divider and then a sign fix-up state.
// One word is in flight at a time; req_tready is low until rsp is taken.
// Synchronous active-high reset clears the controller and the reservation flag.
module rv32_atomic_divide_trap_unit
   import rv32adt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [167:0] req_tdata,  // fetch_ok, instr_word, src1, src2, mem_word, time, pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata   // handled, rd_write, rd_index, rd_data, mem_write, addr, data
);
   cmd_type    cmd;
   status_type status;
   logic [103:0] res;

   rv32adt_control u_ctl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .status, .cmd
   );

   rv32adt_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .fetch_ok(req_tdata[0]),
      .instr_word(req_tdata[32:1]),
      .src1_value(req_tdata[64:33]),
      .src2_value(req_tdata[96:65]),
      .mem_word(req_tdata[128:97]),
      .time_value(req_tdata[160:129]),
      .result(res)
   );

   // reorder from {handled..mem_data} msb-first to lowest-first packing
   assign rsp_tdata = {res[31:0], res[63:32], res[64], res[96:65], res[101:97],
                       res[102], res[103]};
endmodule

// ===== sim/rv32_atomic_divide_trap_unit_test.sv =====
`timescale 1ns / 1ps
module rv32_atomic_divide_trap_unit_test;
   import rv32adt_pkg::*;

   typedef struct packed {
      logic [6:0]  pad;
      logic [31:0] timer;
      logic [31:0] mem_word;
      logic [31:0] src2;
      logic [31:0] src1;
      logic [31:0] instr;
      logic        fetch_ok;
   } trap_word_t;

   typedef struct packed {
      logic [31:0] mem_data;
      logic [31:0] mem_addr;
      logic        mem_write;
      logic [31:0] rd_data;
      logic [4:0]  rd_index;
      logic        rd_write;
      logic        handled;
   } retire_word_t;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int NUM_RANDOM = 1750;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;   // fetch_ok, instr_word, src1, src2, mem_word, time, pad
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;        // handled, rd_write, rd_index, rd_data, mem_write, addr, data

   rv32_atomic_divide_trap_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   trap_word_t   pending_words[$];
   retire_word_t expected_retires[$];
   logic [31:0]  resv_addr;
   logic         resv_valid = 1'b0;
   int           mismatches = 0;
   int           cycles = 0;
   bit           word_taken = 0;
   bit           retire_taken = 0;
   bit           offering = 0;
   int           send_gap = 0;
   int           recv_gap = 0;
   int           hold_left = 0;
   int           sent_count = 0;
   bit           burst = 0;
   logic [31:0]  addr_pool[4];

   function automatic logic [31:0] divide_word(logic [31:0] a, logic [31:0] b,
                                               bit sgn, bit want_rem);
      if (b == 0) return want_rem ? a : 32'hFFFFFFFF;
      if (!sgn) return want_rem ? a % b : a / b;
      if (a == 32'h80000000 && b == 32'hFFFFFFFF) return want_rem ? 32'd0 : a;
      return want_rem ? $signed(a) % $signed(b) : $signed(a) / $signed(b);
   endfunction

   function automatic retire_word_t predict_retire(trap_word_t w);
      retire_word_t r;
      logic [6:0]  opc;
      logic [4:0]  rd, f5;
      logic [2:0]  f3;
      logic [31:0] rdv, mdata;
      bit          ok, wr_rd, wr_mem;
      opc = w.instr[6:0];
      rd = w.instr[11:7];
      f3 = w.instr[14:12];
      f5 = w.instr[31:27];
      ok = 0; wr_rd = 0; wr_mem = 0; rdv = 0; mdata = 0;
      r = '0;
      if (w.fetch_ok) begin
         if (opc == OPC_SYSTEM) begin
            if (f3 == F3_WORD && w.instr[31:20] == CSR_TIME) begin
               ok = 1; wr_rd = 1; rdv = w.timer;
            end else if (f3 == F3_WORD && w.instr[31:20] == CSR_TIMEH) begin
               ok = 1; wr_rd = 1; rdv = 0;
            end
         end else if (opc == OPC_OP) begin
            if (w.instr[31:25] == F7_MULDIV && f3[2]) begin
               ok = 1; wr_rd = 1;
               rdv = divide_word(w.src1, w.src2, !f3[0], f3[1]);
            end
         end else if (opc == OPC_AMO && f3 == F3_WORD) begin
            ok = 1; wr_rd = 1; rdv = w.mem_word; wr_mem = 1;
            case (f5)
               F5_LR: begin
                  wr_mem = 0; resv_addr = w.src1; resv_valid = 1;
               end
               F5_SC: begin
                  if (resv_valid && resv_addr == w.src1) begin
                     mdata = w.src2; rdv = 0;
                  end else begin
                     wr_mem = 0; rdv = 1;
                  end
                  resv_valid = 0;
               end
               F5_SWAP: mdata = w.src2;
               F5_ADD:  mdata = w.mem_word + w.src2;
               F5_XOR:  mdata = w.mem_word ^ w.src2;
               F5_AND:  mdata = w.mem_word & w.src2;
               F5_OR:   mdata = w.mem_word | w.src2;
               F5_MIN:  mdata = ($signed(w.mem_word) < $signed(w.src2)) ? w.mem_word : w.src2;
               F5_MAX:  mdata = ($signed(w.mem_word) > $signed(w.src2)) ? w.mem_word : w.src2;
               F5_MINU: mdata = (w.mem_word < w.src2) ? w.mem_word : w.src2;
               F5_MAXU: mdata = (w.mem_word > w.src2) ? w.mem_word : w.src2;
               default: begin
                  ok = 0; wr_rd = 0; wr_mem = 0;
               end
            endcase
         end
      end
      r.handled = ok;
      if (ok && wr_rd && rd != 0) begin
         r.rd_write = 1; r.rd_index = rd; r.rd_data = rdv;
      end
      if (ok && wr_mem) begin
         r.mem_write = 1; r.mem_addr = w.src1; r.mem_data = mdata;
      end
      return r;
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'hFFFFFFFF;
         2: return 32'h80000000;
         3: return 32'h7FFFFFFF;
         4: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [4:0] pick_amo_op();
      logic [4:0] ops[9];
      ops = '{F5_SWAP, F5_ADD, F5_XOR, F5_AND, F5_OR, F5_MIN, F5_MAX, F5_MINU, F5_MAXU};
      return ops[$urandom_range(0, 8)];
   endfunction

   function automatic trap_word_t make_word(int kind);
      trap_word_t w;
      logic [4:0] rd, f5;
      w.pad = '0;
      w.fetch_ok = 1;
      w.src1 = pick_operand();
      w.src2 = pick_operand();
      w.mem_word = pick_operand();
      w.timer = $urandom;
      rd = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom);
      case (kind)
         0: w.instr = {F7_MULDIV, 10'($urandom), 1'b1, 2'($urandom), rd, OPC_OP};
         1: w.instr = {pick_amo_op(), 7'($urandom), 5'($urandom), F3_WORD, rd, OPC_AMO};
         2: begin
            w.src1 = addr_pool[$urandom_range(0, 3)];
            w.instr = {F5_LR, 7'($urandom), 5'($urandom), F3_WORD, rd, OPC_AMO};
         end
         3: begin
            w.src1 = addr_pool[$urandom_range(0, 3)];
            w.instr = {F5_SC, 7'($urandom), 5'($urandom), F3_WORD, rd, OPC_AMO};
         end
         4: w.instr = {$urandom_range(0, 1) ? CSR_TIME : CSR_TIMEH, 5'($urandom),
                       F3_WORD, rd, OPC_SYSTEM};
         default: begin
            case ($urandom_range(0, 5))
               0: w.instr = $urandom;
               1: begin
                  w = make_word($urandom_range(0, 4));
                  w.fetch_ok = 0;
               end
               2: w.instr = {7'($urandom), 10'($urandom), 3'($urandom), rd, OPC_OP};
               3: w.instr = {$urandom_range(0, 1) ? 12'($urandom) : CSR_TIME,
                             5'($urandom), 3'($urandom), rd, OPC_SYSTEM};
               4: begin
                  f5 = 5'($urandom);
                  w.instr = {f5, 7'($urandom), 5'($urandom), 3'($urandom), rd, OPC_AMO};
               end
               default: w.instr = {F7_MULDIV, 10'($urandom), 1'b0, 2'($urandom), rd, OPC_OP};
            endcase
         end
      endcase
      return w;
   endfunction

   initial begin
      trap_word_t w;
      int kind;
      for (int i = 0; i < 4; i++) addr_pool[i] = $urandom;
      // division corner cases: by zero and signed overflow, all four ops
      for (int f = 0; f < 4; f++) begin
         w = make_word(0);
         w.instr[13:12] = 2'(f);
         w.src2 = 0;
         pending_words.push_back(w);
         w = make_word(0);
         w.instr[13:12] = 2'(f);
         w.src1 = 32'h80000000; w.src2 = 32'hFFFFFFFF;
         pending_words.push_back(w);
      end
      // SC without reservation, then LR/SC pair, then SC to a different address
      w = make_word(3); pending_words.push_back(w);
      w = make_word(2); w.src1 = addr_pool[0]; pending_words.push_back(w);
      w = make_word(3); w.src1 = addr_pool[0]; pending_words.push_back(w);
      w = make_word(2); w.src1 = addr_pool[1]; pending_words.push_back(w);
      w = make_word(3); w.src1 = addr_pool[2]; pending_words.push_back(w);
      w = make_word(4); w.instr[31:20] = CSR_TIME; w.instr[11:7] = 5'd31;
      w.timer = 32'hFFFFFFFF; pending_words.push_back(w);
      w = make_word(4); w.instr[31:20] = CSR_TIMEH; pending_words.push_back(w);
      w = make_word(1); w.instr[11:7] = 5'd0; pending_words.push_back(w);
      w = make_word(1); w.fetch_ok = 0; pending_words.push_back(w);
      w = make_word(1); w.instr[14:12] = 3'b011; pending_words.push_back(w);
      for (int i = 0; i < NUM_RANDOM; i++) begin
         kind = $urandom_range(0, 11);
         if (kind > 5) kind = (kind < 9) ? $urandom_range(2, 3) : $urandom_range(0, 4);
         pending_words.push_back(make_word(kind));
      end
      repeat (4) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      wait (pending_words.size() == 0 && !offering && expected_retires.size() == 0);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_retires.size() == 0)
         $display("rv32_atomic_divide_trap_unit_test passed");
      else
         $display("rv32_atomic_divide_trap_unit_test failed");
      $finish;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("rv32_atomic_divide_trap_unit_test failed");
         $finish;
      end
      if (!reset && req_tvalid && req_tready) begin
         expected_retires.push_back(predict_retire(trap_word_t'(req_tdata)));
         word_taken = 1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         retire_taken = 1;
         if (expected_retires.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_tdata);
         end else if (retire_word_t'(rsp_tdata) !== expected_retires[0]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %p actual %p", expected_retires[0],
                        retire_word_t'(rsp_tdata));
            void'(expected_retires.pop_front());
         end else begin
            void'(expected_retires.pop_front());
         end
      end
   end

   // sender: advance the queue on each taken word, draw a gap per word
   always @(negedge clock) begin
      if (!reset) begin
         if (word_taken) begin
            word_taken = 0;
            offering = 0;
            void'(pending_words.pop_front());
            sent_count++;
            if (sent_count % 150 == 0) burst = !burst;
            send_gap = burst ? 0 : $urandom_range(0, 13);
         end
         if (!offering && pending_words.size() > 0) begin
            if (send_gap == 0) begin
               offering = 1;
               req_tdata <= pending_words[0];
            end else begin
               send_gap--;
            end
         end
         req_tvalid <= offering;
      end
   end

   // long receiver hold-off to stall the input side
   always @(negedge clock) begin
      if (cycles == 3000) hold_left = 600;
      else if (hold_left > 0) hold_left--;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (retire_taken) begin
            retire_taken = 0;
            recv_gap = burst ? 0 : $urandom_range(0, 13);
         end else if (recv_gap > 0) begin
            recv_gap--;
         end
         rsp_tready <= (recv_gap == 0 && hold_left == 0);
      end
   end

endmodule
